[rtl/atrp_pkg.sv]
// Shared types, constants and the CORDIC angle table for the tilt block.
package atrp_pkg;

  localparam int AXIS_W     = 14;  // axis value width
  localparam int VEC_SHIFT  = 8;   // axis value to CORDIC vector scaling
  localparam int VEC_W      = 25;  // CORDIC x/y width incl. gain growth
  localparam int ANG_W      = 26;  // Q16 degree accumulator width
  localparam int INNER_FRAC = 16;
  localparam int TABLE_SIZE = 24;
  localparam int GAIN_W     = 18;
  localparam int PROD_W     = VEC_W + GAIN_W;
  localparam int ROLL_W     = 16;
  localparam int PITCH_W    = 15;

  localparam logic signed [GAIN_W-1:0] INV_GAIN_Q16 = GAIN_W'(39797);
  localparam logic signed [ANG_W-1:0]  DEG180_Q16   = ANG_W'(180 << INNER_FRAC);
  localparam logic signed [ANG_W-1:0]  DEG90_Q16    = ANG_W'(90 << INNER_FRAC);

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [ANG_W-1:0]  ang_t;

  // Sideband that travels with each sample down the chain.
  typedef struct packed {
    axis_t ax;
    axis_t ay;
    axis_t az;
    logic  roll_zero;
    logic  pitch_zero;
    ang_t  roll_q16;
  } side_t;

  // round(atan(2^-i) * 180/pi * 65536)
  function automatic ang_t atan_deg_q16(input int i);
    ang_t v;
    case (i)
      0:  v = ANG_W'(2949120);
      1:  v = ANG_W'(1740967);
      2:  v = ANG_W'(919879);
      3:  v = ANG_W'(466945);
      4:  v = ANG_W'(234379);
      5:  v = ANG_W'(117304);
      6:  v = ANG_W'(58666);
      7:  v = ANG_W'(29335);
      8:  v = ANG_W'(14668);
      9:  v = ANG_W'(7334);
      10: v = ANG_W'(3667);
      11: v = ANG_W'(1833);
      12: v = ANG_W'(917);
      13: v = ANG_W'(458);
      14: v = ANG_W'(229);
      15: v = ANG_W'(115);
      16: v = ANG_W'(57);
      17: v = ANG_W'(29);
      18: v = ANG_W'(14);
      19: v = ANG_W'(7);
      20: v = ANG_W'(4);
      21: v = ANG_W'(2);
      22: v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/accel_tilt_roll_pitch.sv]
// Top level: accelerometer roll and pitch through two chained CORDIC cell rows.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in_     | sink      | in_valid/in_stall  | x/y/z high and low sample bytes
//  out_    | source    | out_valid/out_stall| accel_x/y/z, roll_angle, pitch_angle
//
//  One transaction per cycle sustained while out_stall is low. Data passes through the
//  roll cell row, two gain compensation stages (multiply, then round and clamp),
//  pitch cell row, then the result register.
//  Every stage has its own valid bit and loads when empty or when the stage after
//  it moves, so bubbles collapse and in_stall rises only when the whole chain is full.
//  rst_n (synchronous) clears the valid bits only; payload registers are not reset.
module accel_tilt_roll_pitch #(
  parameter int CORDIC_STAGES       = 16,
  parameter int ANGLE_FRACTION_BITS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_x_high_byte,
  input  logic [7:0]         in_x_low_byte,
  input  logic [7:0]         in_y_high_byte,
  input  logic [7:0]         in_y_low_byte,
  input  logic [7:0]         in_z_high_byte,
  input  logic [7:0]         in_z_low_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [13:0] out_accel_x,
  output logic signed [13:0] out_accel_y,
  output logic signed [13:0] out_accel_z,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle
);
  import atrp_pkg::*;

  // Signed word / 4, truncated toward zero: bias negatives by 3 before the shift.
  function automatic axis_t axis_value(input logic [7:0] hi, input logic [7:0] lo);
    logic signed [16:0] w;
    logic signed [16:0] q;
    w = 17'($signed({hi, lo}));
    q = (w + (w[16] ? 17'sd3 : 17'sd0)) >>> 2;
    return q[AXIS_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Input conditioning: axis values, left half plane fold, zero detection
  // ---------------------------------------------------------------------------
  axis_t ax, ay, az;
  vec_t  vz, vy;
  vec_t  fold_x, fold_y;
  ang_t  fold_ang;
  side_t in_side;

  vec_t  r_x   [CORDIC_STAGES+1];
  vec_t  r_y   [CORDIC_STAGES+1];
  ang_t  r_ang [CORDIC_STAGES+1];
  side_t r_side[CORDIC_STAGES+1];
  logic  r_valid[CORDIC_STAGES+1];
  logic  r_ready[CORDIC_STAGES+1];

  always_comb begin
    ax = axis_value(in_x_high_byte, in_x_low_byte);
    ay = axis_value(in_y_high_byte, in_y_low_byte);
    az = axis_value(in_z_high_byte, in_z_low_byte);
    vz = VEC_W'($signed({az, {VEC_SHIFT{1'b0}}}));
    vy = VEC_W'($signed({ay, {VEC_SHIFT{1'b0}}}));

    in_side            = '0;
    in_side.ax         = ax;
    in_side.ay         = ay;
    in_side.az         = az;
    in_side.roll_zero  = (ay == '0) && (az == '0);

    // z < 0: rotate by 180 degrees first so the cells see x >= 0
    if (az[AXIS_W-1]) begin
      fold_x   = -vz;
      fold_y   = -vy;
      fold_ang = ay[AXIS_W-1] ? -DEG180_Q16 : DEG180_Q16;
    end else begin
      fold_x   = vz;
      fold_y   = vy;
      fold_ang = '0;
    end
  end

  assign r_x[0]     = fold_x;
  assign r_y[0]     = fold_y;
  assign r_ang[0]   = fold_ang;
  assign r_side[0]  = in_side;
  assign r_valid[0] = in_valid;
  assign in_stall   = !r_ready[0];

  // ---------------------------------------------------------------------------
  // Roll pass: atan2(y, z) and gained magnitude of (z, y)
  // ---------------------------------------------------------------------------
  logic gc_ready;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_roll
    atrp_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (r_valid[g]),
      .up_ready (r_ready[g]),
      .up_x     (r_x[g]),
      .up_y     (r_y[g]),
      .up_ang   (r_ang[g]),
      .up_side  (r_side[g]),
      .dn_valid (r_valid[g+1]),
      .dn_ready ((g == CORDIC_STAGES - 1) ? gc_ready : r_ready[g+1]),
      .dn_x     (r_x[g+1]),
      .dn_y     (r_y[g+1]),
      .dn_ang   (r_ang[g+1]),
      .dn_side  (r_side[g+1])
    );
  end

  assign r_ready[CORDIC_STAGES] = gc_ready;

  // ---------------------------------------------------------------------------
  // Gain compensation, pitch pass set-up
  // ---------------------------------------------------------------------------
  vec_t  p_x   [CORDIC_STAGES+1];
  vec_t  p_y   [CORDIC_STAGES+1];
  ang_t  p_ang [CORDIC_STAGES+1];
  side_t p_side[CORDIC_STAGES+1];
  logic  p_valid[CORDIC_STAGES+1];
  logic  p_ready[CORDIC_STAGES+1];

  atrp_gain_comp u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (r_valid[CORDIC_STAGES]),
    .up_ready (gc_ready),
    .up_mag   (r_x[CORDIC_STAGES]),
    .up_ang   (r_ang[CORDIC_STAGES]),
    .up_side  (r_side[CORDIC_STAGES]),
    .dn_valid (p_valid[0]),
    .dn_ready (p_ready[0]),
    .dn_x     (p_x[0]),
    .dn_y     (p_y[0]),
    .dn_ang   (p_ang[0]),
    .dn_side  (p_side[0])
  );

  // ---------------------------------------------------------------------------
  // Pitch pass: atan2(x, compensated magnitude)
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_pitch
    atrp_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (p_valid[g]),
      .up_ready (p_ready[g]),
      .up_x     (p_x[g]),
      .up_y     (p_y[g]),
      .up_ang   (p_ang[g]),
      .up_side  (p_side[g]),
      .dn_valid (p_valid[g+1]),
      .dn_ready (p_ready[g+1]),
      .dn_x     (p_x[g+1]),
      .dn_y     (p_y[g+1]),
      .dn_ang   (p_ang[g+1]),
      .dn_side  (p_side[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Saturate, round, result register
  // ---------------------------------------------------------------------------
  atrp_finish #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (p_valid[CORDIC_STAGES]),
    .up_ready        (p_ready[CORDIC_STAGES]),
    .up_ang          (p_ang[CORDIC_STAGES]),
    .up_side         (p_side[CORDIC_STAGES]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accel_x     (out_accel_x),
    .out_accel_y     (out_accel_y),
    .out_accel_z     (out_accel_z),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle)
  );

  // x/y of the last pitch cell are not needed
  logic unused_tail;
  assign unused_tail = ^{p_x[CORDIC_STAGES], p_y[CORDIC_STAGES], r_y[CORDIC_STAGES]};

endmodule

[rtl/atrp_cordic_cell.sv]
// One CORDIC vectoring micro-rotation with its pipeline register.
module atrp_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  atrp_pkg::vec_t        up_x,
  input  atrp_pkg::vec_t        up_y,
  input  atrp_pkg::ang_t        up_ang,
  input  atrp_pkg::side_t       up_side,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output atrp_pkg::vec_t        dn_x,
  output atrp_pkg::vec_t        dn_y,
  output atrp_pkg::ang_t        dn_ang,
  output atrp_pkg::side_t       dn_side
);
  import atrp_pkg::*;

  localparam ang_t STEP_ANG = atan_deg_q16(STAGE);

  logic  valid_r;
  vec_t  x_r, y_r, x_nxt, y_nxt, xs, ys;
  ang_t  ang_r, ang_nxt;
  side_t side_r;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    xs = up_x >>> STAGE;
    ys = up_y >>> STAGE;
    if (!up_y[VEC_W-1]) begin
      x_nxt   = up_x + ys;
      y_nxt   = up_y - xs;
      ang_nxt = up_ang + STEP_ANG;
    end else begin
      x_nxt   = up_x - ys;
      y_nxt   = up_y + xs;
      ang_nxt = up_ang - STEP_ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      ang_r  <= ang_nxt;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_ang   = ang_r;
  assign dn_side  = side_r;

endmodule

[rtl/atrp_gain_comp.sv]
// Gain compensation of the roll magnitude and set-up of the pitch pass.
module atrp_gain_comp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  atrp_pkg::vec_t        up_mag,
  input  atrp_pkg::ang_t        up_ang,
  input  atrp_pkg::side_t       up_side,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output atrp_pkg::vec_t        dn_x,
  output atrp_pkg::vec_t        dn_y,
  output atrp_pkg::ang_t        dn_ang,
  output atrp_pkg::side_t       dn_side
);
  import atrp_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1 << (INNER_FRAC - 1));

  // stage a: product
  logic                     a_valid_r, a_ready;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, mag_ext, gain_ext;
  side_t                    a_side_r, a_side_nxt;

  // stage b: compensated magnitude
  logic                     b_valid_r;
  logic signed [PROD_W-1:0] comp_full;
  vec_t                     comp_nxt, x_r, y_r;
  side_t                    side_r, side_nxt;

  assign mag_ext  = PROD_W'(up_mag);
  assign gain_ext = PROD_W'(INV_GAIN_Q16);
  assign prod_nxt = mag_ext * gain_ext;

  always_comb begin
    a_side_nxt          = up_side;
    a_side_nxt.roll_q16 = up_side.roll_zero ? '0 : up_ang;
  end

  assign a_ready  = !b_valid_r || dn_ready;
  assign up_ready = !a_valid_r || a_ready;

  always_comb begin
    comp_full = (prod_r + HALF_LSB) >>> INNER_FRAC;
    comp_nxt  = comp_full[PROD_W-1] ? '0 : VEC_W'(comp_full);
    side_nxt            = a_side_r;
    side_nxt.pitch_zero = (a_side_r.ax == '0) && (comp_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (up_ready) a_valid_r <= up_valid;
      if (a_ready)  b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r   <= prod_nxt;
      a_side_r <= a_side_nxt;
    end
    if (a_ready && a_valid_r) begin
      x_r    <= comp_nxt;
      y_r    <= VEC_W'($signed({a_side_r.ax, {VEC_SHIFT{1'b0}}}));
      side_r <= side_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_ang   = '0;
  assign dn_side  = side_r;

endmodule

[rtl/atrp_finish.sv]
// Angle saturation, rounding and the result register.
module atrp_finish #(
  parameter int ANGLE_FRACTION_BITS = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  atrp_pkg::ang_t                up_ang,
  input  atrp_pkg::side_t               up_side,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [13:0]            out_accel_x,
  output logic signed [13:0]            out_accel_y,
  output logic signed [13:0]            out_accel_z,
  output logic signed [15:0]            out_roll_angle,
  output logic signed [14:0]            out_pitch_angle
);
  import atrp_pkg::*;

  localparam int   SHIFT = INNER_FRAC - ANGLE_FRACTION_BITS;
  localparam ang_t ROUND = ANG_W'(1 << (SHIFT - 1));

  function automatic ang_t finish(input ang_t a, input ang_t lim);
    ang_t c;
    ang_t r;
    if (a > lim)       c = lim;
    else if (a < -lim) c = -lim;
    else               c = a;
    r = (c + ROUND) >>> SHIFT;
    return r;
  endfunction

  logic  valid_r;
  ang_t  roll_f, pitch_f;
  axis_t ax_r, ay_r, az_r;
  logic signed [ROLL_W-1:0]  roll_r;
  logic signed [PITCH_W-1:0] pitch_r;

  assign up_ready = !valid_r || !out_stall;

  always_comb begin
    roll_f  = finish(up_side.roll_q16, DEG180_Q16);
    pitch_f = finish(up_side.pitch_zero ? '0 : up_ang, DEG90_Q16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ax_r    <= up_side.ax;
      ay_r    <= up_side.ay;
      az_r    <= up_side.az;
      roll_r  <= roll_f[ROLL_W-1:0];
      pitch_r <= pitch_f[PITCH_W-1:0];
    end
  end

  assign out_valid       = valid_r;
  assign out_accel_x     = ax_r;
  assign out_accel_y     = ay_r;
  assign out_accel_z     = az_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;

endmodule
